// ===== hw/rtl/pcx_pkg.sv =====
// Shared types, constants and helper functions for the PCX run-length scanline decoder.
// No dependencies; pcx_front, pcx_back and the top level import it, pcx_fifo does not.
package pcx_pkg;

  localparam int unsigned CMD_DEPTH_LOG2 = 2;
  localparam int unsigned OUT_DEPTH_LOG2 = 1;

  localparam logic [15:0] LINE_WIDTH_RST  = 16'd320;
  localparam logic        RLE_ENABLE_RST  = 1'b1;
  localparam logic [2:0]  PLANE_COUNT_RST = 3'd1;

  localparam logic [1:0] CFG_LINE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_RLE_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_PLANE_COUNT = 2'd2;

  localparam logic [1:0] RUN_MARK = 2'b11;

  typedef struct packed {
    logic [15:0] line_width;
    logic        rle_enable;
    logic [2:0]  plane_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [15:0] column;
    logic [1:0]  plane;
    logic        run_last;
    logic        line_end;
  } pix_t;

  function automatic logic [15:0] eff_width(input logic [15:0] w);
    eff_width = (w == 16'd0) ? 16'd1 : w;
  endfunction

  function automatic logic [2:0] eff_planes(input logic [2:0] p);
    if (p == 3'd0) begin
      eff_planes = 3'd1;
    end else if (p > 3'd4) begin
      eff_planes = 3'd4;
    end else begin
      eff_planes = p;
    end
  endfunction

endpackage

// ===== hw/rtl/pcx_fifo.sv =====
// Small first-in first-out queue of packed words, held in a register array.
// Depends on nothing but its parameters; used for the command queue and the result queue.
module pcx_fifo #(
  parameter int unsigned WIDTH      = 8,
  parameter int unsigned DEPTH_LOG2 = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [DEPTH_LOG2-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [DEPTH_LOG2:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == (DEPTH_LOG2+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/pcx_front.sv =====
// Front end of the decoder: takes raw stream bytes, holds a pending run count and
// queues one command (value and repeat count) per byte that yields pixels. Uses pcx_pkg.
module pcx_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rle_enable,
  input  logic          in_push,
  input  logic [7:0]    in_byte,
  input  logic          cmd_full,
  output logic          cmd_push,
  output pcx_pkg::cmd_t cmd_data
);
  import pcx_pkg::*;

  logic       awaiting_r, awaiting_nxt;
  logic [5:0] held_r, held_nxt;
  logic       accept;

  assign accept = in_push && !cmd_full;

  always_comb begin
    awaiting_nxt   = awaiting_r;
    held_nxt       = held_r;
    cmd_push       = 1'b0;
    cmd_data.value = in_byte;
    cmd_data.count = 6'd1;
    if (accept) begin
      if (!rle_enable) begin
        // Pass-through: every byte is one pixel and a pending count is dropped.
        awaiting_nxt = 1'b0;
        held_nxt     = '0;
        cmd_push     = 1'b1;
      end else if (awaiting_r) begin
        awaiting_nxt   = 1'b0;
        held_nxt       = '0;
        cmd_data.count = held_r;
        cmd_push       = (held_r != 6'd0);
      end else if (in_byte[7:6] == RUN_MARK) begin
        awaiting_nxt = 1'b1;
        held_nxt     = in_byte[5:0];
      end else begin
        cmd_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      held_r     <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

// ===== hw/rtl/pcx_back.sv =====
// Back end of the decoder: expands queued commands into pixels, one a cycle while the
// result queue it feeds has room, and tracks the line position and plane. Uses pcx_pkg.
module pcx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pcx_pkg::cfg_t cfg,
  input  logic          lw_wr,
  input  logic [15:0]   lw_data,
  input  logic          cmd_empty,
  input  pcx_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  input  logic          out_full,
  output logic          out_push,
  output pcx_pkg::pix_t out_data
);
  import pcx_pkg::*;

  logic [15:0] pixels_left_r, pixels_left_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic        busy_r, busy_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [5:0]  cur_count;
  logic [15:0] width;
  logic [2:0]  planes;
  logic [2:0]  plane_inc;
  logic        emit, end_px, last;

  assign width     = eff_width(cfg.line_width);
  assign planes    = eff_planes(cfg.plane_count);
  assign plane_inc = {1'b0, plane_r} + 3'd1;
  assign cur_count = busy_r ? rem_r : cmd_data.count;
  assign emit      = !cmd_empty && !out_full;
  assign end_px    = (pixels_left_r <= 16'd1);
  // A run stops at the line end; what is left of it is dropped with the command.
  assign last      = (cur_count == 6'd1) || end_px;
  assign cmd_pop   = emit && last;
  assign out_push  = emit;

  always_comb begin
    out_data.pixel_value = cmd_data.value;
    out_data.column      = width - pixels_left_r;
    out_data.plane       = plane_r;
    out_data.run_last    = last;
    out_data.line_end    = end_px;
  end

  always_comb begin
    pixels_left_nxt = pixels_left_r;
    plane_nxt       = plane_r;
    busy_nxt        = busy_r;
    rem_nxt         = rem_r;
    if (lw_wr) begin
      pixels_left_nxt = eff_width(lw_data);
    end else if (emit) begin
      busy_nxt = !last;
      rem_nxt  = cur_count - 6'd1;
      if (end_px) begin
        pixels_left_nxt = width;
        plane_nxt       = (plane_inc >= planes) ? 2'd0 : plane_inc[1:0];
      end else begin
        pixels_left_nxt = pixels_left_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= LINE_WIDTH_RST;
      plane_r       <= '0;
      busy_r        <= 1'b0;
      rem_r         <= '0;
    end else begin
      pixels_left_r <= pixels_left_nxt;
      plane_r       <= plane_nxt;
      busy_r        <= busy_nxt;
      rem_r         <= rem_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_marks_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_push && out_data.line_end |-> out_data.run_last)
    else $error("line end pixel without run-last mark");
  a_column_in_line : assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_data.column < width))
    else $error("pixel column beyond line width");
  a_line_restart : assert property (@(posedge clk) disable iff (!rst_n)
    out_push && out_data.line_end && !lw_wr |=> pixels_left_r == $past(width))
    else $error("line counter not reloaded after line end");
  a_busy_needs_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !cmd_empty)
    else $error("run in progress with no command queued");
`endif

endmodule

// ===== hw/rtl/pcx_rle_scanline_decoder_unit.sv =====
// Top level of the PCX run-length scanline decoder: configuration registers,
// front end, command queue, back end and result queue. Uses pcx_pkg and all pcx_ modules.
//
//   Channel  Handshake                      Payload
//   in_      in_push / in_full              in_byte
//   out_     out_pop / out_empty            out_pixel_value, out_column, out_plane,
//                                           out_run_last, out_line_end
//   cfg_     cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A literal byte yields one pixel; a run of n pixels (fewer if cut at a line end) is
// expanded one pixel per cycle from its expansion counter while the result queue has room.
// A count byte yields no pixel itself. The command queue holds
// four requests so the front keeps taking bytes while a run is expanded.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
module pcx_rle_scanline_decoder_unit #(
  parameter int unsigned CMD_DEPTH_LOG2 = pcx_pkg::CMD_DEPTH_LOG2,
  parameter int unsigned OUT_DEPTH_LOG2 = pcx_pkg::OUT_DEPTH_LOG2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_pixel_value,
  output logic [15:0] out_column,
  output logic [1:0]  out_plane,
  output logic        out_run_last,
  output logic        out_line_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pcx_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr, lw_wr;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_wr, cmd_rd;
  logic pix_push, pix_full;
  pix_t pix_wr, pix_rd;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign lw_wr     = cfg_wr && (cfg_index == CFG_LINE_WIDTH);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_LINE_WIDTH:  cfg_nxt.line_width  = cfg_data;
        CFG_RLE_ENABLE:  cfg_nxt.rle_enable  = cfg_data[0];
        CFG_PLANE_COUNT: cfg_nxt.plane_count = cfg_data[2:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width  <= LINE_WIDTH_RST;
      cfg_r.rle_enable  <= RLE_ENABLE_RST;
      cfg_r.plane_count <= PLANE_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = cmd_full;

  pcx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .rle_enable (cfg_r.rle_enable),
    .in_push    (in_push),
    .in_byte    (in_byte),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_wr)
  );

  pcx_fifo #(
    .WIDTH      ($bits(cmd_t)),
    .DEPTH_LOG2 (CMD_DEPTH_LOG2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  pcx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .lw_wr     (lw_wr),
    .lw_data   (cfg_data),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rd),
    .cmd_pop   (cmd_pop),
    .out_full  (pix_full),
    .out_push  (pix_push),
    .out_data  (pix_wr)
  );

  pcx_fifo #(
    .WIDTH      ($bits(pix_t)),
    .DEPTH_LOG2 (OUT_DEPTH_LOG2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (pix_push),
    .wr_data (pix_wr),
    .full    (pix_full),
    .pop     (out_pop),
    .rd_data (pix_rd),
    .empty   (out_empty)
  );

  assign out_pixel_value = pix_rd.pixel_value;
  assign out_column      = pix_rd.column;
  assign out_plane       = pix_rd.plane;
  assign out_run_last    = pix_rd.run_last;
  assign out_line_end    = pix_rd.line_end;

endmodule
